### rtl/fpum_pkg.sv
// Package for the fisheye polar unwrap map: field widths, register codes,
// pipeline stage map and the fixed-point constants of the sine/cosine series.
// No dependencies.
package fpum_pkg;

  localparam int COL_W      = 13;
  localparam int ROW_W      = 12;
  localparam int OUT_W      = 26;
  localparam int CX_W       = 21;
  localparam int CY_W       = 20;
  localparam int RAD_W      = 21;
  localparam int GAIN_W     = 16;
  localparam int MW_W       = 14;
  localparam int MH_W       = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;

  localparam int MAX_WIDTH  = 8192;
  localparam int MAX_HEIGHT = 4096;
  localparam int ANGLE_BITS = 16;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INNER    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_X   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_Y   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd7;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

  // restoring divider: 36 quotient bits, 4 per stage
  localparam int DIV_NUM_W = 36;
  localparam int DIV_DEN_W = 14;
  localparam int DIV_STEP  = 4;
  localparam int DIV_STG   = DIV_NUM_W / DIV_STEP;
  localparam int RNUM_W    = 34;

  localparam int R_W    = 35;
  localparam int TRIG_W = 18;
  localparam int Y_W    = 31;
  localparam int SQ_W   = 32;
  localparam int T_W    = 31;
  localparam int YP_W   = ANGLE_BITS + 31;
  localparam int F_W    = ANGLE_BITS - 2;

  localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;
  localparam logic [31:0] Q30_ONE    = 32'h4000_0000;
  localparam logic [32:0] TWO_POW32  = 33'h1_0000_0000;

  localparam int HORNER = 4;
  localparam logic [7:0]  SIN_DIV0 = 8'd110;
  localparam logic [7:0]  COS_DIV0 = 8'd132;
  localparam logic [31:0] SIN_RCP0 = 32'(TWO_POW32 / 33'd110);
  localparam logic [31:0] COS_RCP0 = 32'(TWO_POW32 / 33'd132);
  localparam logic [7:0]  SIN_DIV [HORNER] = '{8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [7:0]  COS_DIV [HORNER] = '{8'd90, 8'd56, 8'd30, 8'd12};
  localparam logic [31:0] SIN_RCP [HORNER] = '{
    32'(TWO_POW32 / 33'd72), 32'(TWO_POW32 / 33'd42),
    32'(TWO_POW32 / 33'd20), 32'(TWO_POW32 / 33'd6)};
  localparam logic [31:0] COS_RCP [HORNER] = '{
    32'(TWO_POW32 / 33'd90), 32'(TWO_POW32 / 33'd56),
    32'(TWO_POW32 / 33'd30), 32'(TWO_POW32 / 33'd12)};

  // stage map
  localparam int ST_PRE   = 1;
  localparam int ST_DIV   = 2;
  localparam int TRIG_STG = 6 + 3 * HORNER;
  localparam int ST_TRIG  = ST_DIV + DIV_STG;
  localparam int AXIS_STG = 4;
  localparam int ST_AXIS  = ST_TRIG + TRIG_STG;
  localparam int NSTG     = ST_AXIS + AXIS_STG;

  // fix a reciprocal quotient estimate that may be one short
  function automatic logic [31:0] cdiv_fix(input logic [31:0] x, input logic [31:0] q_est,
                                           input logic [7:0] c);
    logic [39:0] rem;
    rem = {8'd0, x} - 40'(q_est) * 40'(c);
    return (rem >= 40'(c)) ? q_est + 32'd1 : q_est;
  endfunction

endpackage

### rtl/fpum_div.sv
// Pipelined restoring divider, four quotient bits per stage.
// Depends on fpum_pkg.
module fpum_div (
  input  logic                           clk,
  input  logic [fpum_pkg::DIV_STG-1:0]   en,
  input  logic [fpum_pkg::DIV_NUM_W-1:0] num,
  input  logic [fpum_pkg::DIV_DEN_W-1:0] den,
  output logic [fpum_pkg::DIV_NUM_W-1:0] quo
);
  import fpum_pkg::*;

  typedef struct packed {
    logic [DIV_DEN_W-1:0] rem;
    logic [DIV_NUM_W-1:0] nq;
  } div_state_t;

  function automatic div_state_t div_steps(input div_state_t s, input logic [DIV_DEN_W-1:0] d);
    div_state_t o;
    logic [DIV_DEN_W:0] r2;
    o = s;
    for (int i = 0; i < DIV_STEP; i++) begin
      r2 = {o.rem, o.nq[DIV_NUM_W-1]};
      if (r2 >= {1'b0, d}) begin
        r2   = r2 - {1'b0, d};
        o.nq = {o.nq[DIV_NUM_W-2:0], 1'b1};
      end else begin
        o.nq = {o.nq[DIV_NUM_W-2:0], 1'b0};
      end
      o.rem = r2[DIV_DEN_W-1:0];
    end
    return o;
  endfunction

  div_state_t           st_in;
  div_state_t           st [DIV_STG];
  logic [DIV_DEN_W-1:0] dn [DIV_STG-1];

  assign st_in.rem = '0;
  assign st_in.nq  = num;

  for (genvar j = 0; j < DIV_STG; j++) begin : g_stg
    if (j == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en[j]) begin
          st[j] <= div_steps(st_in, den);
          dn[j] <= den;
        end
      end
    end else if (j < DIV_STG - 1) begin : g_mid
      always_ff @(posedge clk) begin
        if (en[j]) begin
          st[j] <= div_steps(st[j-1], dn[j-1]);
          dn[j] <= dn[j-1];
        end
      end
    end else begin : g_last
      always_ff @(posedge clk) begin
        if (en[j]) begin
          st[j] <= div_steps(st[j-1], dn[j-1]);
        end
      end
    end
  end

  assign quo = st[DIV_STG-1].nq;

endmodule

### rtl/fpum_trig.sv
// Sine/cosine pipeline: turn fraction to signed Q16 (sin, cos) pair via
// Horner-form series with reciprocal constant division. Depends on fpum_pkg.
module fpum_trig (
  input  logic                                clk,
  input  logic [fpum_pkg::TRIG_STG-1:0]       en,
  input  logic [fpum_pkg::ANGLE_BITS-1:0]     angle,
  output logic signed [fpum_pkg::TRIG_W-1:0]  sn,
  output logic signed [fpum_pkg::TRIG_W-1:0]  cs
);
  import fpum_pkg::*;

  localparam int LAST = TRIG_STG - 1;

  logic [1:0]      q_l  [0:LAST-1];
  logic [Y_W-1:0]  y_l  [0:LAST-2];
  logic [SQ_W-1:0] sq_l [1:LAST-2];
  logic [YP_W-1:0] yprod;
  logic [61:0]     sqprod;
  logic [63:0]     ms2, mc2;
  logic [T_W-1:0]  ts [HORNER+1];
  logic [T_W-1:0]  tc [HORNER+1];
  logic [31:0]     hx_s [HORNER];
  logic [31:0]     hx_c [HORNER];
  logic [31:0]     hxm_s [HORNER];
  logic [31:0]     hxm_c [HORNER];
  logic [63:0]     hm_s [HORNER];
  logic [63:0]     hm_c [HORNER];
  logic [61:0]     sprod;
  logic [62:0]     cprod;
  logic [30:0]     s30, hc, c30;
  logic [30:0]     s_rnd, c_rnd;
  logic signed [TRIG_W-1:0] s16, c16;

  assign yprod  = YP_W'(angle[F_W-1:0]) * YP_W'(TWO_PI_Q30);
  assign sqprod = 62'(y_l[0]) * 62'(y_l[0]);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      q_l[0] <= angle[ANGLE_BITS-1 -: 2];
      y_l[0] <= yprod[YP_W-1:ANGLE_BITS];
    end
    if (en[1]) begin
      sq_l[1] <= sqprod[61:30];
    end
    if (en[2]) begin
      ms2 <= 64'(sq_l[1]) * 64'(SIN_RCP0);
      mc2 <= 64'(sq_l[1]) * 64'(COS_RCP0);
    end
    if (en[3]) begin
      ts[0] <= T_W'(Q30_ONE - cdiv_fix(sq_l[2], ms2[63:32], SIN_DIV0));
      tc[0] <= T_W'(Q30_ONE - cdiv_fix(sq_l[2], mc2[63:32], COS_DIV0));
    end
  end

  for (genvar i = 1; i < LAST; i++) begin : g_quad
    always_ff @(posedge clk) begin
      if (en[i]) q_l[i] <= q_l[i-1];
    end
  end

  for (genvar i = 1; i < LAST - 1; i++) begin : g_y
    always_ff @(posedge clk) begin
      if (en[i]) y_l[i] <= y_l[i-1];
    end
  end

  for (genvar i = 2; i < LAST - 1; i++) begin : g_sq
    always_ff @(posedge clk) begin
      if (en[i]) sq_l[i] <= sq_l[i-1];
    end
  end

  for (genvar k = 0; k < HORNER; k++) begin : g_horner
    logic [62:0] px_s, px_c;
    assign px_s = 63'(sq_l[3+3*k]) * 63'(ts[k]);
    assign px_c = 63'(sq_l[3+3*k]) * 63'(tc[k]);
    always_ff @(posedge clk) begin
      if (en[4+3*k]) begin
        hx_s[k] <= px_s[61:30];
        hx_c[k] <= px_c[61:30];
      end
      if (en[5+3*k]) begin
        hm_s[k]  <= 64'(hx_s[k]) * 64'(SIN_RCP[k]);
        hm_c[k]  <= 64'(hx_c[k]) * 64'(COS_RCP[k]);
        hxm_s[k] <= hx_s[k];
        hxm_c[k] <= hx_c[k];
      end
      if (en[6+3*k]) begin
        ts[k+1] <= T_W'(Q30_ONE - cdiv_fix(hxm_s[k], hm_s[k][63:32], SIN_DIV[k]));
        tc[k+1] <= T_W'(Q30_ONE - cdiv_fix(hxm_c[k], hm_c[k][63:32], COS_DIV[k]));
      end
    end
  end

  assign sprod = 62'(y_l[LAST-2]) * 62'(ts[HORNER]);
  assign cprod = 63'(sq_l[LAST-2]) * 63'(tc[HORNER]);

  always_ff @(posedge clk) begin
    if (en[LAST-1]) begin
      s30 <= sprod[60:30];
      hc  <= cprod[61:31];
    end
  end

  assign c30   = (hc >= Q30_ONE[30:0]) ? '0 : Q30_ONE[30:0] - hc;
  assign s_rnd = s30 + 31'd8192;
  assign c_rnd = c30 + 31'd8192;
  assign s16   = $signed({1'b0, s_rnd[30:14]});
  assign c16   = $signed({1'b0, c_rnd[30:14]});

  always_ff @(posedge clk) begin
    if (en[LAST]) begin
      unique case (q_l[LAST-1])
        2'd0: begin sn <= s16;  cs <= c16;  end
        2'd1: begin sn <= c16;  cs <= -s16; end
        2'd2: begin sn <= -s16; cs <= -c16; end
        2'd3: begin sn <= -c16; cs <= s16;  end
      endcase
    end
  end

endmodule

### rtl/fpum_axis.sv
// One output axis: radius times trig value, gain, rounding, center add and
// saturation over four stages. Depends on fpum_pkg.
module fpum_axis (
  input  logic                               clk,
  input  logic [fpum_pkg::AXIS_STG-1:0]      en,
  input  logic signed [fpum_pkg::R_W-1:0]    radius,
  input  logic signed [fpum_pkg::TRIG_W-1:0] trig,
  input  logic [fpum_pkg::GAIN_W-1:0]        gain,
  input  logic [fpum_pkg::CX_W-1:0]          center,
  output logic signed [fpum_pkg::OUT_W-1:0]  coord
);
  import fpum_pkg::*;

  localparam int P1_W  = R_W + TRIG_W;
  localparam int P_W   = P1_W - 15;
  localparam int P2_W  = P_W + GAIN_W + 1;
  localparam int DX_W  = P2_W - 11;
  localparam int SUM_W = DX_W + 1;

  localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'(33554431);
  localparam logic signed [SUM_W-1:0] OUT_MIN = -SUM_W'(33554432);

  logic signed [P1_W-1:0]  prod1;
  logic [P1_W-1:0]         m1, m1r;
  logic signed [P_W-1:0]   p;
  logic signed [P2_W-1:0]  prod2;
  logic [P2_W-1:0]         m2, m2r;
  logic signed [SUM_W-1:0] sum;

  assign m1  = prod1[P1_W-1] ? P1_W'(-prod1) : prod1;
  assign m1r = m1 + P1_W'(1 << 15);
  assign m2  = prod2[P2_W-1] ? P2_W'(-prod2) : prod2;
  assign m2r = m2 + P2_W'(1 << 11);

  always_comb begin
    logic signed [SUM_W-1:0] dx;
    dx  = prod2[P2_W-1] ? -$signed({1'b0, m2r[P2_W-1:12]}) : $signed({1'b0, m2r[P2_W-1:12]});
    sum = $signed(SUM_W'(center)) + dx;
  end

  always_ff @(posedge clk) begin
    if (en[0]) prod1 <= P1_W'(radius) * P1_W'(trig);
    if (en[1]) begin
      p <= prod1[P1_W-1] ? -$signed({1'b0, m1r[P1_W-1:16]}) : $signed({1'b0, m1r[P1_W-1:16]});
    end
    if (en[2]) prod2 <= P2_W'(p) * $signed(P2_W'(gain));
    if (en[3]) begin
      priority if (sum > OUT_MAX) coord <= OUT_MAX[OUT_W-1:0];
      else if (sum < OUT_MIN)     coord <= OUT_MIN[OUT_W-1:0];
      else                        coord <= sum[OUT_W-1:0];
    end
  end

endmodule

### rtl/fisheye_polar_unwrap_map.sv
// Fisheye polar unwrap map: for each panorama pixel (column, row) gives the fisheye source
// coordinate in signed Q17.8. Throughput is one pixel per clock while out_ready is high;
// a result beat follows its pixel beat through 33 register stages: the 36-bit restoring
// dividers (four bits per stage) for angle and radius, then the Horner sine/cosine chain
// (three stages per term) and the four-stage gain/offset path.
// Each stage holds its own valid bit, so bubbles close up while the output waits. Register
// writes on cfg_valid are taken every cycle. Depends on fpum_pkg, fpum_div, fpum_trig,
// fpum_axis.
module fisheye_polar_unwrap_map (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [fpum_pkg::COL_W-1:0]           column,
  input  logic [fpum_pkg::ROW_W-1:0]           row,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [fpum_pkg::OUT_W-1:0]    source_x,
  output logic signed [fpum_pkg::OUT_W-1:0]    source_y,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [fpum_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fpum_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import fpum_pkg::*;

  logic [CX_W-1:0]   center_x;
  logic [CY_W-1:0]   center_y;
  logic [RAD_W-1:0]  inner_radius_px, outer_radius_px;
  logic [GAIN_W-1:0] gain_x, gain_y;
  logic [MW_W-1:0]   map_width, w_eff;
  logic [MH_W-1:0]   map_height, h_eff;

  logic [NSTG-1:0] v, en;

  logic [COL_W-1:0]       col0;
  logic [ROW_W-1:0]       row0;
  logic [DIV_NUM_W-1:0]   num_a, num_r, quo_a, quo_r;
  logic [DIV_DEN_W-1:0]   den_a, den_r;
  logic signed [RAD_W:0]  dr;
  logic [RAD_W-1:0]       dmag;
  logic                   neg_l [ST_PRE:ST_TRIG-1];
  logic signed [R_W-1:0]  r_l [ST_TRIG:ST_AXIS-1];
  logic signed [R_W-1:0]  qs;
  logic signed [TRIG_W-1:0] sn, cs;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x        <= '0;
      center_y        <= '0;
      inner_radius_px <= '0;
      outer_radius_px <= '0;
      gain_x          <= GAIN_RESET;
      gain_y          <= GAIN_RESET;
      map_width       <= MW_W'(1);
      map_height      <= MH_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CENTER_X: center_x        <= cfg_data[CX_W-1:0];
        REG_CENTER_Y: center_y        <= cfg_data[CY_W-1:0];
        REG_INNER:    inner_radius_px <= cfg_data[RAD_W-1:0];
        REG_OUTER:    outer_radius_px <= cfg_data[RAD_W-1:0];
        REG_GAIN_X:   gain_x          <= cfg_data[GAIN_W-1:0];
        REG_GAIN_Y:   gain_y          <= cfg_data[GAIN_W-1:0];
        REG_WIDTH:    map_width       <= cfg_data[MW_W-1:0];
        REG_HEIGHT:   map_height      <= cfg_data[MH_W-1:0];
      endcase
    end
  end

  always_comb begin
    priority if (map_width == '0)          w_eff = MW_W'(1);
    else if (map_width > MW_W'(MAX_WIDTH)) w_eff = MW_W'(MAX_WIDTH);
    else                                   w_eff = map_width;
    priority if (map_height == '0)           h_eff = MH_W'(1);
    else if (map_height > MH_W'(MAX_HEIGHT)) h_eff = MH_W'(MAX_HEIGHT);
    else                                     h_eff = map_height;
  end

  // stage enables: a stage loads when empty or when the next one moves
  assign en[NSTG-1] = !v[NSTG-1] || out_ready;
  for (genvar i = 0; i < NSTG - 1; i++) begin : g_en
    assign en[i] = !v[i] || en[i+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[NSTG-1];

  assign dr   = $signed({1'b0, outer_radius_px}) - $signed({1'b0, inner_radius_px});
  assign dmag = dr[RAD_W] ? RAD_W'(-dr) : dr[RAD_W-1:0];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      col0 <= column;
      row0 <= row;
    end
    if (en[ST_PRE]) begin
      num_a         <= DIV_NUM_W'({col0, ANGLE_BITS'(0)});
      den_a         <= w_eff;
      num_r         <= DIV_NUM_W'(RNUM_W'(dmag) * RNUM_W'(row0) + RNUM_W'(h_eff >> 1));
      den_r         <= DIV_DEN_W'(h_eff);
      neg_l[ST_PRE] <= dr[RAD_W];
    end
  end

  for (genvar i = ST_PRE + 1; i < ST_TRIG; i++) begin : g_neg
    always_ff @(posedge clk) begin
      if (en[i]) neg_l[i] <= neg_l[i-1];
    end
  end

  fpum_div u_div_angle (
    .clk (clk),
    .en  (en[ST_DIV +: DIV_STG]),
    .num (num_a),
    .den (den_a),
    .quo (quo_a)
  );

  fpum_div u_div_radius (
    .clk (clk),
    .en  (en[ST_DIV +: DIV_STG]),
    .num (num_r),
    .den (den_r),
    .quo (quo_r)
  );

  assign qs = $signed({1'b0, quo_r[R_W-2:0]});

  always_ff @(posedge clk) begin
    if (en[ST_TRIG]) begin
      r_l[ST_TRIG] <= $signed(R_W'(inner_radius_px)) + (neg_l[ST_TRIG-1] ? -qs : qs);
    end
  end

  for (genvar i = ST_TRIG + 1; i < ST_AXIS; i++) begin : g_rad
    always_ff @(posedge clk) begin
      if (en[i]) r_l[i] <= r_l[i-1];
    end
  end

  fpum_trig u_trig (
    .clk   (clk),
    .en    (en[ST_TRIG +: TRIG_STG]),
    .angle (quo_a[ANGLE_BITS-1:0]),
    .sn    (sn),
    .cs    (cs)
  );

  fpum_axis u_axis_x (
    .clk    (clk),
    .en     (en[ST_AXIS +: AXIS_STG]),
    .radius (r_l[ST_AXIS-1]),
    .trig   (sn),
    .gain   (gain_x),
    .center (center_x),
    .coord  (source_x)
  );

  fpum_axis u_axis_y (
    .clk    (clk),
    .en     (en[ST_AXIS +: AXIS_STG]),
    .radius (r_l[ST_AXIS-1]),
    .trig   (cs),
    .gain   (gain_y),
    .center (CX_W'(center_y)),
    .coord  (source_y)
  );

endmodule

### rtl/fpum_chk.sv
// Port-level checker for fisheye_polar_unwrap_map, bound to the top level.
// Depends on fpum_pkg.
module fpum_chk (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [fpum_pkg::COL_W-1:0]        column,
  input logic [fpum_pkg::ROW_W-1:0]        row,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [fpum_pkg::OUT_W-1:0] source_x,
  input logic signed [fpum_pkg::OUT_W-1:0] source_y,
  input logic                              cfg_valid,
  input logic                              cfg_ready,
  input logic [fpum_pkg::CFG_IDX_W-1:0]    cfg_index,
  input logic [fpum_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import fpum_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(source_x) && $stable(source_y))
    else $error("result beat changed while stalled");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with output stage empty");

  a_ready_when_taken: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result beat right after reset");

endmodule

bind fisheye_polar_unwrap_map fpum_chk u_fpum_chk (.*);
